// ===== sv/tptgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tptgc_pkg
// Shared widths, defaults and gesture codes for the touch gesture classifier.
// ----------------------------------------------------------------------------
package tptgc_pkg;

    // default coordinate width; the top level may override it
    localparam int COORD_BITS_DEF = 12;

    // move threshold register width
    localparam int THR_BITS = 12;

    localparam int KIND1_BITS = 3;
    localparam int KIND2_BITS = 2;

    typedef logic [KIND1_BITS-1:0] kind1_t;
    typedef logic [KIND2_BITS-1:0] kind2_t;
    typedef logic [THR_BITS-1:0]   thr_t;

    // first contact gesture codes
    localparam kind1_t KIND1_NONE        = 3'd0;
    localparam kind1_t KIND1_TAP         = 3'd1;
    localparam kind1_t KIND1_SLIDE_BEGIN = 3'd2;
    localparam kind1_t KIND1_SLIDE       = 3'd3;
    localparam kind1_t KIND1_SLIDE_END   = 3'd4;

    // second contact gesture codes
    localparam kind2_t KIND2_NONE  = 2'd0;
    localparam kind2_t KIND2_TAP   = 2'd1;
    localparam kind2_t KIND2_SLIDE = 2'd3;

endpackage

// ===== sv/tptgc_if.sv =====
// ----------------------------------------------------------------------------
// tptgc_if
// Valid/ready channels: touch poll in, gesture result out, threshold write.
// ----------------------------------------------------------------------------
interface tptgc_poll_if #(
    parameter int COORD_BITS = tptgc_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  first_present;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic                  second_present;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;

    modport source (
        output valid, first_present, first_x, first_y,
               second_present, second_x, second_y,
        input  ready
    );
    modport sink (
        input  valid, first_present, first_x, first_y,
               second_present, second_x, second_y,
        output ready
    );
endinterface

interface tptgc_gesture_if #(
    parameter int COORD_BITS = tptgc_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    tptgc_pkg::kind1_t     first_kind;
    logic [COORD_BITS-1:0] first_out_x;
    logic [COORD_BITS-1:0] first_out_y;
    tptgc_pkg::kind2_t     second_kind;
    logic [COORD_BITS-1:0] second_out_x;
    logic [COORD_BITS-1:0] second_out_y;

    modport source (
        output valid, first_kind, first_out_x, first_out_y,
               second_kind, second_out_x, second_out_y,
        input  ready
    );
    modport sink (
        input  valid, first_kind, first_out_x, first_out_y,
               second_kind, second_out_x, second_out_y,
        output ready
    );
endinterface

interface tptgc_cfg_if;
    logic              valid;
    logic              ready;
    tptgc_pkg::thr_t   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/two_point_touch_gesture_classifier_core.sv =====
// ----------------------------------------------------------------------------
// two_point_touch_gesture_classifier_core
// Classifies two-contact touch polls into tap / slide gestures.
// ----------------------------------------------------------------------------
// One poll transfer can be taken every clock cycle unless a poll with a gesture
// waits for the result register. A poll lands in an input register, is
// classified there by a single stage of compare and select logic against
// the stored contact state, and any gesture goes into the result register,
// which drives result valid. Polls that yield no gesture (both kinds none)
// update the state and produce no result transfer. The input stage keeps
// moving while a result is waiting, as long as the polls behind it give no
// gesture; a poll that does give one waits in the input register until the
// result register is free.
// move_threshold is written through the cfg channel, which is always ready;
// write it only while no poll is in flight.
// ----------------------------------------------------------------------------
module two_point_touch_gesture_classifier_core #(
    parameter int COORD_BITS = tptgc_pkg::COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    tptgc_cfg_if.sink              cfg,
    tptgc_poll_if.sink             poll,
    tptgc_gesture_if.source        gesture
);

    // compare width wide enough for both a coordinate delta and the threshold
    localparam int CMP_W = (COORD_BITS > tptgc_pkg::THR_BITS) ? COORD_BITS
                                                                : tptgc_pkg::THR_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    tptgc_pkg::thr_t thr_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic   in_valid_reg;
    logic   p1_reg, p2_reg;
    coord_t x1_reg, y1_reg, x2_reg, y2_reg;

    logic   s1_fire;
    logic   has_result;
    logic   out_free;

    // a poll with no gesture never needs the result register
    assign s1_fire    = in_valid_reg && (out_free || !has_result);
    assign poll.ready = !in_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            in_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            p1_reg <= poll.first_present;
            x1_reg <= poll.first_x;
            y1_reg <= poll.first_y;
            p2_reg <= poll.second_present;
            x2_reg <= poll.second_x;
            y2_reg <= poll.second_y;
        end
    end

    // ------------------------------------------------------------------
    // contact state
    // ------------------------------------------------------------------
    coord_t prev_x1_reg, prev_y1_reg, prev_x2_reg, prev_y2_reg;
    coord_t prev_x1_next, prev_y1_next, prev_x2_next, prev_y2_next;
    logic   was1_reg, was2_reg, sliding_reg;
    logic   sliding_next;

    // ------------------------------------------------------------------
    // classification
    // ------------------------------------------------------------------
    coord_t dx1, dy1, dx2, dy2;
    logic   moved1, moved2;

    tptgc_pkg::kind1_t kind1;
    tptgc_pkg::kind2_t kind2;

    always_comb
    begin
        dx1 = (x1_reg >= prev_x1_reg) ? x1_reg - prev_x1_reg : prev_x1_reg - x1_reg;
        dy1 = (y1_reg >= prev_y1_reg) ? y1_reg - prev_y1_reg : prev_y1_reg - y1_reg;
        dx2 = (x2_reg >= prev_x2_reg) ? x2_reg - prev_x2_reg : prev_x2_reg - x2_reg;
        dy2 = (y2_reg >= prev_y2_reg) ? y2_reg - prev_y2_reg : prev_y2_reg - y2_reg;

        moved1 = (cmp_t'(dx1) > cmp_t'(thr_reg)) || (cmp_t'(dy1) > cmp_t'(thr_reg));
        moved2 = (cmp_t'(dx2) > cmp_t'(thr_reg)) || (cmp_t'(dy2) > cmp_t'(thr_reg));
    end

    // first contact
    always_comb
    begin
        kind1         = tptgc_pkg::KIND1_NONE;
        sliding_next  = sliding_reg;
        prev_x1_next  = '0;
        prev_y1_next  = '0;
        if (p1_reg)
        begin
            if (was1_reg && moved1)
            begin
                kind1        = sliding_reg ? tptgc_pkg::KIND1_SLIDE
                                           : tptgc_pkg::KIND1_SLIDE_BEGIN;
                sliding_next = 1'b1;
            end
            prev_x1_next = x1_reg;
            prev_y1_next = y1_reg;
        end
        else if (was1_reg)
        begin
            // release: report at the last known position
            kind1        = sliding_reg ? tptgc_pkg::KIND1_SLIDE_END
                                       : tptgc_pkg::KIND1_TAP;
            sliding_next = 1'b0;
            prev_x1_next = prev_x1_reg;
            prev_y1_next = prev_y1_reg;
        end
    end

    // second contact
    always_comb
    begin
        kind2        = tptgc_pkg::KIND2_NONE;
        prev_x2_next = '0;
        prev_y2_next = '0;
        if (p2_reg)
        begin
            if (was2_reg && moved2)
            begin
                kind2 = tptgc_pkg::KIND2_SLIDE;
            end
            prev_x2_next = x2_reg;
            prev_y2_next = y2_reg;
        end
        else if (was2_reg)
        begin
            kind2        = tptgc_pkg::KIND2_TAP;
            prev_x2_next = prev_x2_reg;
            prev_y2_next = prev_y2_reg;
        end
    end

    assign has_result = (kind1 != tptgc_pkg::KIND1_NONE) ||
                        (kind2 != tptgc_pkg::KIND2_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x1_reg <= '0;
            prev_y1_reg <= '0;
            prev_x2_reg <= '0;
            prev_y2_reg <= '0;
            was1_reg    <= 1'b0;
            was2_reg    <= 1'b0;
            sliding_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            prev_x1_reg <= prev_x1_next;
            prev_y1_reg <= prev_y1_next;
            prev_x2_reg <= prev_x2_next;
            prev_y2_reg <= prev_y2_next;
            was1_reg    <= p1_reg;
            was2_reg    <= p2_reg;
            sliding_reg <= sliding_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    tptgc_pkg::kind1_t kind1_reg;
    tptgc_pkg::kind2_t kind2_reg;
    coord_t            ox1_reg, oy1_reg, ox2_reg, oy2_reg;
    logic              load_out;

    assign out_free = !out_valid_reg || gesture.ready;
    assign load_out = s1_fire && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (gesture.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // a contact with no gesture reports zero coordinates
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind1_reg <= kind1;
            kind2_reg <= kind2;
            ox1_reg   <= (kind1 == tptgc_pkg::KIND1_NONE) ? '0 : prev_x1_next;
            oy1_reg   <= (kind1 == tptgc_pkg::KIND1_NONE) ? '0 : prev_y1_next;
            ox2_reg   <= (kind2 == tptgc_pkg::KIND2_NONE) ? '0 : prev_x2_next;
            oy2_reg   <= (kind2 == tptgc_pkg::KIND2_NONE) ? '0 : prev_y2_next;
        end
    end

    assign gesture.valid        = out_valid_reg;
    assign gesture.first_kind   = kind1_reg;
    assign gesture.first_out_x  = ox1_reg;
    assign gesture.first_out_y  = oy1_reg;
    assign gesture.second_kind  = kind2_reg;
    assign gesture.second_out_x = ox2_reg;
    assign gesture.second_out_y = oy2_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // every result transfer carries at least one gesture
    a_result_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind1_reg != tptgc_pkg::KIND1_NONE) ||
                          (kind2_reg != tptgc_pkg::KIND2_NONE))
        else $error("result with no gesture");

    // a first contact with no gesture reports the origin
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind1_reg == tptgc_pkg::KIND1_NONE) |->
            (ox1_reg == '0) && (oy1_reg == '0))
        else $error("non-zero coordinates with no first gesture");

    // sliding only while the first contact is down
    a_slide_down: assert property (@(posedge clk) disable iff (!rst_n)
        sliding_reg |-> was1_reg)
        else $error("sliding flag set with first contact up");

    // release clears the slide
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !p1_reg) |=> !sliding_reg)
        else $error("slide survived release");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !gesture.ready) |-> !load_out)
        else $error("result register overwritten while stalled");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-contact touch gesture classifier.
// ----------------------------------------------------------------------------
// A model of the classifier inside the bench tracks both contacts, the slide
// flag and the threshold. For every poll transfer it works out the gesture
// that should follow, if any, and queues it. A monitor on the gesture channel
// takes each result transfer and compares it, field by field, with the oldest
// queued gesture.
//
// The stimulus starts with a short directed run: new presses, taps, a full
// slide from begin to end, the threshold boundary and both threshold
// extremes. Random touch sessions follow under several thresholds. Both the
// poll source and the gesture sink idle at random, and one phase runs flat
// out.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CB        = tptgc_pkg::COORD_BITS_DEF;
    localparam int COORD_MAX = (1 << CB) - 1;
    localparam int SETTLE    = 8;          // pipeline is two stages deep
    localparam int MAX_IDLE  = 10;
    localparam int LIMIT_NS  = 3_000_000;

    typedef logic [CB-1:0] coord_t;

    // one touch-controller poll
    typedef struct packed {
        logic   first_present;
        coord_t first_x;
        coord_t first_y;
        logic   second_present;
        coord_t second_x;
        coord_t second_y;
    } poll_t;

    // one gesture result, laid out like the output channel
    typedef struct packed {
        tptgc_pkg::kind1_t first_kind;
        coord_t            first_out_x;
        coord_t            first_out_y;
        tptgc_pkg::kind2_t second_kind;
        coord_t            second_out_x;
        coord_t            second_out_y;
    } gesture_t;

    logic clk;
    logic rst_n;

    tptgc_cfg_if                         cfg_ch ();
    tptgc_poll_if    #(.COORD_BITS(CB))  poll_ch ();
    tptgc_gesture_if #(.COORD_BITS(CB))  gesture_ch ();

    two_point_touch_gesture_classifier_core #(
        .COORD_BITS (CB)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch.sink),
        .poll    (poll_ch.sink),
        .gesture (gesture_ch.source)
    );

    // ------------------------------------------------------------------
    // Classifier model state
    // ------------------------------------------------------------------
    tptgc_pkg::thr_t threshold;
    coord_t last_first_x, last_first_y;
    coord_t last_second_x, last_second_y;
    logic   first_down, second_down, first_in_slide;

    gesture_t pending_gestures [$];

    // bookkeeping
    int  polls_sent;
    int  gestures_seen;
    int  threshold_writes;
    int  fail_count;
    bit  idle_on;

    // random touch-session generator state
    bit  roam_first_on, roam_second_on;
    int  roam_first_x, roam_first_y, roam_second_x, roam_second_y;

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Timeout: %0d gestures still awaited", pending_gestures.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model: a contact has moved when either axis differs by strictly more
    // than the threshold.
    // ------------------------------------------------------------------
    function automatic bit has_moved(coord_t x, coord_t y, coord_t px, coord_t py);
        int dx;
        int dy;
        dx = int'(x) - int'(px);
        dy = int'(y) - int'(py);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx > int'(threshold)) || (dy > int'(threshold));
    endfunction

    // Advance the model by one accepted poll; queue any gesture it yields.
    // Coordinates in the gesture stay zero whenever that contact's kind is none.
    function automatic void classify_poll(poll_t p);
        gesture_t g;
        g = '0;

        // first contact
        if (p.first_present)
        begin
            if (first_down && has_moved(p.first_x, p.first_y, last_first_x, last_first_y))
            begin
                if (first_in_slide)
                    g.first_kind = tptgc_pkg::KIND1_SLIDE;
                else
                begin
                    g.first_kind   = tptgc_pkg::KIND1_SLIDE_BEGIN;
                    first_in_slide = 1'b1;
                end
                g.first_out_x = p.first_x;
                g.first_out_y = p.first_y;
            end
            last_first_x = p.first_x;
            last_first_y = p.first_y;
        end
        else if (first_down)
        begin
            // release: report at last position, which is kept
            g.first_kind   = first_in_slide ? tptgc_pkg::KIND1_SLIDE_END
                                            : tptgc_pkg::KIND1_TAP;
            g.first_out_x  = last_first_x;
            g.first_out_y  = last_first_y;
            first_in_slide = 1'b0;
        end
        else
        begin
            last_first_x = '0;
            last_first_y = '0;
        end

        // second contact
        if (p.second_present)
        begin
            if (second_down && has_moved(p.second_x, p.second_y, last_second_x, last_second_y))
            begin
                g.second_kind  = tptgc_pkg::KIND2_SLIDE;
                g.second_out_x = p.second_x;
                g.second_out_y = p.second_y;
            end
            last_second_x = p.second_x;
            last_second_y = p.second_y;
        end
        else if (second_down)
        begin
            g.second_kind  = tptgc_pkg::KIND2_TAP;
            g.second_out_x = last_second_x;
            g.second_out_y = last_second_y;
        end
        else
        begin
            last_second_x = '0;
            last_second_y = '0;
        end

        first_down  = p.first_present;
        second_down = p.second_present;

        if (g.first_kind != tptgc_pkg::KIND1_NONE || g.second_kind != tptgc_pkg::KIND2_NONE)
            pending_gestures.push_back(g);
    endfunction

    // ------------------------------------------------------------------
    // Poll source
    // ------------------------------------------------------------------
    // presence flags take bit 0 of their argument
    function automatic poll_t make_poll(int fp, int fx, int fy, int sp, int sx, int sy);
        poll_t p;
        p.first_present  = fp[0];
        p.first_x        = coord_t'(fx);
        p.first_y        = coord_t'(fy);
        p.second_present = sp[0];
        p.second_x       = coord_t'(sx);
        p.second_y       = coord_t'(sy);
        return p;
    endfunction

    // Send one poll; returns at the edge of its transfer with valid still high,
    // so a back-to-back poll keeps valid up without a glitch.
    task automatic send_poll(input poll_t p);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_ch.valid          <= 1'b1;
        poll_ch.first_present  <= p.first_present;
        poll_ch.first_x        <= p.first_x;
        poll_ch.first_y        <= p.first_y;
        poll_ch.second_present <= p.second_present;
        poll_ch.second_x       <= p.second_x;
        poll_ch.second_y       <= p.second_y;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        classify_poll(p);
        polls_sent++;
    endtask

    // Stop sending, wait for every queued gesture, then let no-gesture polls
    // still in the pipe settle.
    task automatic drain_pipeline();
        poll_ch.valid <= 1'b0;
        while (pending_gestures.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(input tptgc_pkg::thr_t value);
        drain_pipeline();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        threshold = value;
        threshold_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random touch sessions
    // ------------------------------------------------------------------
    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // One contact's next sample: stay put, wander within the threshold, jump
    // just past it, or leap anywhere; sometimes lift or press.
    function automatic void roam_contact(inout bit on, inout int x, inout int y,
                                         output logic pres, output coord_t px,
                                         output coord_t py);
        int t;
        int step;
        t = int'(threshold);
        if (on && $urandom_range(0, 99) < 12)
        begin
            on   = 1'b0;
            pres = 1'b0;
            px   = coord_t'($urandom);       // ignored while absent
            py   = coord_t'($urandom);
        end
        else if (on)
        begin
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    x = clamp_coord(x + int'($urandom_range(0, 2 * t)) - t);
                    y = clamp_coord(y + int'($urandom_range(0, 2 * t)) - t);
                end
                2:
                begin
                    step = t + int'($urandom_range(1, 3));
                    if ($urandom_range(0, 1))
                        step = -step;
                    if ($urandom_range(0, 1))
                        x = clamp_coord(x + step);
                    else
                        y = clamp_coord(y + step);
                end
                default:
                begin
                    x = $urandom_range(0, COORD_MAX);
                    y = $urandom_range(0, COORD_MAX);
                end
            endcase
            pres = 1'b1;
            px   = coord_t'(x);
            py   = coord_t'(y);
        end
        else if ($urandom_range(0, 99) < 35)
        begin
            on   = 1'b1;
            x    = $urandom_range(0, COORD_MAX);
            y    = $urandom_range(0, COORD_MAX);
            pres = 1'b1;
            px   = coord_t'(x);
            py   = coord_t'(y);
        end
        else
        begin
            pres = 1'b0;
            px   = coord_t'($urandom);
            py   = coord_t'($urandom);
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset threshold (zero): new press, slide begin/slide/end, taps, and
    // coordinate extremes.
    task automatic test_gestures_at_reset_threshold();
        send_poll(make_poll(0, COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX));
        send_poll(make_poll(1, 0, 0, 1, COORD_MAX, COORD_MAX));   // new press: none
        send_poll(make_poll(1, 0, 0, 1, COORD_MAX, COORD_MAX));   // no move
        send_poll(make_poll(1, 1, 0, 1, COORD_MAX, COORD_MAX - 1));
        send_poll(make_poll(1, COORD_MAX, COORD_MAX, 1, COORD_MAX, COORD_MAX - 1));
        send_poll(make_poll(0, 0, 0, 0, 0, 0));                   // slide end + tap
        send_poll(make_poll(0, 0, 0, 0, 0, 0));                   // stored coords clear
        send_poll(make_poll(1, 2730, 1365, 0, 1365, 2730));
        send_poll(make_poll(0, 1365, 2730, 0, 2730, 1365));       // first taps
        send_poll(make_poll(0, 0, 0, 1, 1365, 2730));
        send_poll(make_poll(0, 0, 0, 0, 0, 0));                   // second taps
    endtask

    // Threshold boundary (equal is no move) and both extremes.
    task automatic test_threshold_boundary();
        write_threshold(tptgc_pkg::thr_t'(100));
        send_poll(make_poll(1, 500, 500, 0, 0, 0));
        send_poll(make_poll(1, 600, 500, 0, 0, 0));               // exactly 100: none
        send_poll(make_poll(1, 600, 399, 0, 0, 0));               // 101: slide begin
        send_poll(make_poll(1, 600, 399, 0, 0, 0));
        send_poll(make_poll(0, 0, 0, 0, 0, 0));                   // slide end

        // full-scale threshold: nothing ever counts as a move
        write_threshold(tptgc_pkg::thr_t'(COORD_MAX));
        send_poll(make_poll(1, 0, 0, 1, 0, COORD_MAX));
        send_poll(make_poll(1, COORD_MAX, COORD_MAX, 1, COORD_MAX, 0));
        send_poll(make_poll(0, 0, 0, 0, 0, 0));                   // both tap
    endtask

    // Mostly well-formed touch sessions with random content, some raw noise.
    task automatic test_random_sessions(input tptgc_pkg::thr_t value, input bit idling,
                                        input int count);
        poll_t p;
        write_threshold(value);
        idle_on = idling;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 10)
                p = make_poll($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
            begin
                roam_contact(roam_first_on, roam_first_x, roam_first_y,
                             p.first_present, p.first_x, p.first_y);
                roam_contact(roam_second_on, roam_second_x, roam_second_y,
                             p.second_present, p.second_x, p.second_y);
            end
            send_poll(p);
            // hold the source off until the sink has caught up
            if (i == count / 2)
                drain_pipeline();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Gesture sink and checker
    // ------------------------------------------------------------------
    initial
    begin : gesture_monitor
        gesture_t got;
        gesture_t want;
        int       sink_hold;
        gesture_ch.ready = 1'b0;
        sink_hold        = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (gesture_ch.valid && gesture_ch.ready)
                begin
                    got.first_kind   = gesture_ch.first_kind;
                    got.first_out_x  = gesture_ch.first_out_x;
                    got.first_out_y  = gesture_ch.first_out_y;
                    got.second_kind  = gesture_ch.second_kind;
                    got.second_out_x = gesture_ch.second_out_x;
                    got.second_out_y = gesture_ch.second_out_y;
                    gestures_seen++;
                    if (pending_gestures.size() == 0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR %0t: unexpected gesture k1=%0d (%0d,%0d) k2=%0d (%0d,%0d)",
                                     $realtime, got.first_kind, got.first_out_x, got.first_out_y,
                                     got.second_kind, got.second_out_x, got.second_out_y);
                    end
                    else
                    begin
                        want = pending_gestures.pop_front();
                        if (got.first_kind   !== want.first_kind   ||
                            got.first_out_x  !== want.first_out_x  ||
                            got.first_out_y  !== want.first_out_y  ||
                            got.second_kind  !== want.second_kind  ||
                            got.second_out_x !== want.second_out_x ||
                            got.second_out_y !== want.second_out_y)
                        begin
                            fail_count++;
                            if (fail_count <= 10)
                            begin
                                $display("ERROR %0t: gesture %0d mismatch", $realtime,
                                         gestures_seen);
                                $display("  want k1=%0d (%0d,%0d) k2=%0d (%0d,%0d)",
                                         want.first_kind, want.first_out_x, want.first_out_y,
                                         want.second_kind, want.second_out_x,
                                         want.second_out_y);
                                $display("  got  k1=%0d (%0d,%0d) k2=%0d (%0d,%0d)",
                                         got.first_kind, got.first_out_x, got.first_out_y,
                                         got.second_kind, got.second_out_x,
                                         got.second_out_y);
                            end
                        end
                    end
                    sink_hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
                end
                else if (sink_hold > 0)
                    sink_hold--;
                gesture_ch.ready <= (sink_hold == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.data            = '0;
        poll_ch.valid          = 1'b0;
        poll_ch.first_present  = 1'b0;
        poll_ch.first_x        = '0;
        poll_ch.first_y        = '0;
        poll_ch.second_present = 1'b0;
        poll_ch.second_x       = '0;
        poll_ch.second_y       = '0;

        threshold        = '0;
        last_first_x     = '0;
        last_first_y     = '0;
        last_second_x    = '0;
        last_second_y    = '0;
        first_down       = 1'b0;
        second_down      = 1'b0;
        first_in_slide   = 1'b0;
        polls_sent       = 0;
        gestures_seen    = 0;
        threshold_writes = 0;
        fail_count       = 0;
        idle_on          = 1'b1;
        roam_first_on    = 1'b0;
        roam_second_on   = 1'b0;
        roam_first_x     = 0;
        roam_first_y     = 0;
        roam_second_x    = 0;
        roam_second_y    = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gestures_at_reset_threshold();
        test_threshold_boundary();
        test_random_sessions(tptgc_pkg::thr_t'($urandom_range(0, COORD_MAX)), 1'b1, 250);
        test_random_sessions(tptgc_pkg::thr_t'(0), 1'b0, 250);
        test_random_sessions(tptgc_pkg::thr_t'(COORD_MAX), 1'b1, 250);
        test_random_sessions(tptgc_pkg::thr_t'($urandom_range(1, 40)), 1'b1, 250);
        drain_pipeline();

        $display("Run covered %0d polls, %0d gesture transfers and %0d threshold writes",
                 polls_sent, gestures_seen, threshold_writes);
        $display("Thresholds: reset, boundary, both extremes, random; idling on and off");
        if (fail_count == 0 && pending_gestures.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d failures, %0d gestures never seen", fail_count,
                     pending_gestures.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
